[rtl/core/packbits_rle_encoder_defines.svh]
// assertion macros shared by the packbits encoder modules
// no dependencies; included at the top of each file that asserts
`ifndef PACKBITS_RLE_ENCODER_DEFINES_SVH
`define PACKBITS_RLE_ENCODER_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define PBE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define PBE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/pbe_pkg.sv]
// types, constants and helpers for the packbits encoder
// used by pbe_ctrl, pbe_dp and packbits_rle_encoder; no dependencies
package pbe_pkg;

    localparam int WORD_W = 32;
    localparam int CNT_W  = 3;
    localparam logic [8:0] RUN_HDR_BASE = 9'd257;

    typedef logic [7:0] t_byte;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_A_HDR,
        ST_A_MEM,
        ST_A_TAIL0,
        ST_A_TAIL1,
        ST_B_HDR,
        ST_B_VAL
    } t_state;

    // source of the coded byte sent to the packer
    typedef enum logic [2:0] {
        SRC_A_HDR,
        SRC_MEM,
        SRC_TAIL0,
        SRC_TAIL1,
        SRC_B_HDR,
        SRC_B_VAL
    } t_src;

    typedef struct packed {
        logic load;
        logic emit;
        logic fin;
        t_src src;
    } t_cmd;

    typedef struct packed {
        logic adv;
        logic new_a;
        logic new_b;
        logic a_mem_nz;
        logic a_tail_nz;
        logic a_tail_two;
        logic mem_last;
        logic b_valid;
    } t_status;

    function automatic t_byte run_header(input logic [8:0] len);
        return t_byte'(RUN_HDR_BASE - len);
    endfunction

endpackage

[rtl/core/pbe_ctrl.sv]
// controller for the packbits encoder: sequences the coded bytes of each step
// depends on pbe_pkg and packbits_rle_encoder_defines.svh
`include "packbits_rle_encoder_defines.svh"

module pbe_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pbe_pkg::t_status  i_status,
    output pbe_pkg::t_cmd     o_cmd
);

    pbe_pkg::t_state r_state;
    pbe_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pbe_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pbe_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_status.new_a) begin
                        n_state = pbe_pkg::ST_A_HDR;
                    end else if (i_status.new_b) begin
                        n_state = pbe_pkg::ST_B_HDR;
                    end
                end
            end
            pbe_pkg::ST_A_HDR: begin
                if (i_status.adv) begin
                    if (i_status.a_mem_nz) begin
                        n_state = pbe_pkg::ST_A_MEM;
                    end else if (i_status.a_tail_nz) begin
                        n_state = pbe_pkg::ST_A_TAIL0;
                    end else if (i_status.b_valid) begin
                        n_state = pbe_pkg::ST_B_HDR;
                    end else begin
                        n_state = pbe_pkg::ST_IDLE;
                    end
                end
            end
            pbe_pkg::ST_A_MEM: begin
                if (i_status.adv && i_status.mem_last) begin
                    if (i_status.a_tail_nz) begin
                        n_state = pbe_pkg::ST_A_TAIL0;
                    end else if (i_status.b_valid) begin
                        n_state = pbe_pkg::ST_B_HDR;
                    end else begin
                        n_state = pbe_pkg::ST_IDLE;
                    end
                end
            end
            pbe_pkg::ST_A_TAIL0: begin
                if (i_status.adv) begin
                    if (i_status.a_tail_two) begin
                        n_state = pbe_pkg::ST_A_TAIL1;
                    end else if (i_status.b_valid) begin
                        n_state = pbe_pkg::ST_B_HDR;
                    end else begin
                        n_state = pbe_pkg::ST_IDLE;
                    end
                end
            end
            pbe_pkg::ST_A_TAIL1: begin
                if (i_status.adv) begin
                    if (i_status.b_valid) begin
                        n_state = pbe_pkg::ST_B_HDR;
                    end else begin
                        n_state = pbe_pkg::ST_IDLE;
                    end
                end
            end
            pbe_pkg::ST_B_HDR: begin
                if (i_status.adv) begin
                    n_state = pbe_pkg::ST_B_VAL;
                end
            end
            pbe_pkg::ST_B_VAL: begin
                if (i_status.adv) begin
                    n_state = pbe_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pbe_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = (r_state == pbe_pkg::ST_IDLE);
        o_cmd.load = (r_state == pbe_pkg::ST_IDLE) && i_in_valid;
        o_cmd.emit = (r_state != pbe_pkg::ST_IDLE) && i_status.adv;
        // last coded byte of the step closes the word
        o_cmd.fin  = (r_state != pbe_pkg::ST_IDLE) && (n_state == pbe_pkg::ST_IDLE);
        case (r_state)
            pbe_pkg::ST_A_HDR:   o_cmd.src = pbe_pkg::SRC_A_HDR;
            pbe_pkg::ST_A_MEM:   o_cmd.src = pbe_pkg::SRC_MEM;
            pbe_pkg::ST_A_TAIL0: o_cmd.src = pbe_pkg::SRC_TAIL0;
            pbe_pkg::ST_A_TAIL1: o_cmd.src = pbe_pkg::SRC_TAIL1;
            pbe_pkg::ST_B_HDR:   o_cmd.src = pbe_pkg::SRC_B_HDR;
            pbe_pkg::ST_B_VAL:   o_cmd.src = pbe_pkg::SRC_B_VAL;
            default:             o_cmd.src = pbe_pkg::SRC_A_HDR;
        endcase
    end

    `PBE_ASSERT_NXT(a_load_to_hdr, i_clk, i_rst_n, o_cmd.load && i_status.new_a, r_state == pbe_pkg::ST_A_HDR, "packet with literal or run not started after transfer")
    `PBE_ASSERT_IMP(a_fin_emits, i_clk, i_rst_n, o_cmd.fin, o_cmd.emit && i_status.adv, "step closed without emitting a byte")

endmodule

[rtl/core/pbe_dp.sv]
// datapath for the packbits encoder: packet decision, literal store,
// byte packer and output register; depends on pbe_pkg and the defines header
`include "packbits_rle_encoder_defines.svh"

module pbe_dp #(
    parameter int MAX_PACKET = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pbe_pkg::t_cmd                 i_cmd,
    output pbe_pkg::t_status              o_status,
    input  logic [7:0]                    i_in_byte,
    input  logic                          i_in_last,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [pbe_pkg::WORD_W-1:0]    o_out_data,
    output logic [pbe_pkg::CNT_W-1:0]     o_out_count,
    output logic                          o_out_last,
    output logic                          o_out_plane_end
);

    localparam int AddrW = $clog2(MAX_PACKET);
    localparam int RunW  = $clog2(MAX_PACKET + 1);
    localparam logic [RunW-1:0]  RunMax  = RunW'(MAX_PACKET);
    localparam logic [RunW-1:0]  RunTwo  = RunW'(2);
    localparam logic [AddrW-1:0] LitFull = AddrW'(MAX_PACKET - 1);

    // encoder state
    logic [AddrW-1:0]     r_lit_len, n_lit_len;
    pbe_pkg::t_byte       r_run_val, n_run_val;
    logic [RunW-1:0]      r_run_len, n_run_len;
    logic                 r_run_mode, n_run_mode;
    pbe_pkg::t_byte       r_prev, n_prev;
    logic                 r_have_prev, n_have_prev;

    // packets of the current step: A may read the store, B is header plus one byte
    pbe_pkg::t_byte       r_a_hdr, n_a_hdr;
    logic [AddrW-1:0]     r_a_mcnt, n_a_mcnt;
    logic [1:0]           r_a_tcnt, n_a_tcnt;
    pbe_pkg::t_byte       r_a_t0, n_a_t0;
    pbe_pkg::t_byte       r_a_t1, n_a_t1;
    logic                 n_a_valid;
    logic                 r_b_valid, n_b_valid;
    pbe_pkg::t_byte       r_b_hdr, n_b_hdr;
    pbe_pkg::t_byte       r_b_val, n_b_val;
    logic                 r_job_last;

    logic                 w_wr_en;
    logic [RunW-1:0]      w_run_inc;

    // literal store
    pbe_pkg::t_byte       r_mem [MAX_PACKET];
    pbe_pkg::t_byte       r_rd_data;
    logic [AddrW-1:0]     r_idx;
    logic                 w_rd_en;
    logic [AddrW-1:0]     w_rd_addr;

    // packer and output register
    logic [pbe_pkg::WORD_W-1:0] r_acc;
    logic [1:0]                 r_acc_cnt;
    pbe_pkg::t_byte             w_byte;
    logic [pbe_pkg::WORD_W-1:0] w_word;
    logic                       w_push;
    logic                       w_adv;
    logic                       r_out_valid;
    logic [pbe_pkg::WORD_W-1:0] r_out_data;
    logic [pbe_pkg::CNT_W-1:0]  r_out_cnt;
    logic                       r_out_last;
    logic                       r_out_plane_end;

    assign w_run_inc = r_run_len + RunW'(1);

    // greedy packet decision for the incoming byte
    always_comb begin
        n_lit_len   = r_lit_len;
        n_run_val   = r_run_val;
        n_run_len   = r_run_len;
        n_run_mode  = r_run_mode;
        n_prev      = r_prev;
        n_have_prev = r_have_prev;
        n_a_valid   = 1'b0;
        n_a_hdr     = '0;
        n_a_mcnt    = '0;
        n_a_tcnt    = 2'd0;
        n_a_t0      = '0;
        n_a_t1      = '0;
        n_b_valid   = 1'b0;
        n_b_hdr     = '0;
        n_b_val     = '0;
        w_wr_en     = 1'b0;
        if (r_run_mode) begin
            if (i_in_byte == r_run_val && r_run_len < RunMax) begin
                if (w_run_inc == RunMax || i_in_last) begin
                    n_a_valid  = 1'b1;
                    n_a_hdr    = pbe_pkg::run_header(9'(w_run_inc));
                    n_a_tcnt   = 2'd1;
                    n_a_t0     = r_run_val;
                    n_run_mode = 1'b0;
                    n_run_len  = '0;
                end else begin
                    n_run_len = w_run_inc;
                end
            end else begin
                n_a_valid  = 1'b1;
                n_a_hdr    = pbe_pkg::run_header(9'(r_run_len));
                n_a_tcnt   = 2'd1;
                n_a_t0     = r_run_val;
                n_run_mode = 1'b0;
                n_run_len  = '0;
                if (i_in_last) begin
                    n_b_valid = 1'b1;
                    n_b_val   = i_in_byte;
                end else begin
                    n_prev      = i_in_byte;
                    n_have_prev = 1'b1;
                end
            end
        end else if (!r_have_prev) begin
            if (i_in_last) begin
                n_b_valid = 1'b1;
                n_b_val   = i_in_byte;
            end else begin
                n_prev      = i_in_byte;
                n_have_prev = 1'b1;
            end
        end else if (r_lit_len == LitFull) begin
            // held byte completes a full literal window, pair or not
            n_a_valid = 1'b1;
            n_a_hdr   = pbe_pkg::t_byte'(r_lit_len);
            n_a_mcnt  = r_lit_len;
            n_a_tcnt  = 2'd1;
            n_a_t0    = r_prev;
            n_lit_len = '0;
            n_prev    = i_in_byte;
            if (i_in_last) begin
                n_b_valid = 1'b1;
                n_b_val   = i_in_byte;
            end
        end else if (i_in_byte == r_prev) begin
            n_have_prev = 1'b0;
            if (r_lit_len != '0) begin
                n_a_valid = 1'b1;
                n_a_hdr   = pbe_pkg::t_byte'(r_lit_len) - 8'd1;
                n_a_mcnt  = r_lit_len;
                n_lit_len = '0;
            end
            if (RunTwo >= RunMax || i_in_last) begin
                n_b_valid = 1'b1;
                n_b_hdr   = pbe_pkg::run_header(9'd2);
                n_b_val   = i_in_byte;
            end else begin
                n_run_mode = 1'b1;
                n_run_val  = i_in_byte;
                n_run_len  = RunTwo;
            end
        end else begin
            if (i_in_last) begin
                n_a_valid = 1'b1;
                n_a_hdr   = pbe_pkg::t_byte'(r_lit_len) + 8'd1;
                n_a_mcnt  = r_lit_len;
                n_a_tcnt  = 2'd2;
                n_a_t0    = r_prev;
                n_a_t1    = i_in_byte;
                n_lit_len = '0;
            end else begin
                w_wr_en   = 1'b1;
                n_lit_len = r_lit_len + AddrW'(1);
                n_prev    = i_in_byte;
            end
        end
        if (i_in_last) begin
            n_have_prev = 1'b0;
            n_prev      = '0;
            n_lit_len   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lit_len   <= '0;
            r_run_val   <= '0;
            r_run_len   <= '0;
            r_run_mode  <= 1'b0;
            r_prev      <= '0;
            r_have_prev <= 1'b0;
            r_b_valid   <= 1'b0;
            r_a_mcnt    <= '0;
            r_a_tcnt    <= 2'd0;
            r_job_last  <= 1'b0;
        end else if (i_cmd.load) begin
            r_lit_len   <= n_lit_len;
            r_run_val   <= n_run_val;
            r_run_len   <= n_run_len;
            r_run_mode  <= n_run_mode;
            r_prev      <= n_prev;
            r_have_prev <= n_have_prev;
            r_b_valid   <= n_b_valid;
            r_a_mcnt    <= n_a_mcnt;
            r_a_tcnt    <= n_a_tcnt;
            r_job_last  <= i_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a_hdr <= n_a_hdr;
            r_a_t0  <= n_a_t0;
            r_a_t1  <= n_a_t1;
            r_b_hdr <= n_b_hdr;
            r_b_val <= n_b_val;
        end
    end

    // store reads run one byte ahead of the packer
    assign w_rd_en   = i_cmd.emit &&
                       (i_cmd.src == pbe_pkg::SRC_A_HDR || i_cmd.src == pbe_pkg::SRC_MEM);
    assign w_rd_addr = (i_cmd.src == pbe_pkg::SRC_A_HDR) ? '0 : r_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_wr_en) begin
            r_mem[r_lit_len] <= r_prev;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.emit && i_cmd.src == pbe_pkg::SRC_A_HDR) begin
            r_idx <= AddrW'(1);
        end else if (i_cmd.emit && i_cmd.src == pbe_pkg::SRC_MEM) begin
            r_idx <= r_idx + AddrW'(1);
        end
    end

    always_comb begin
        case (i_cmd.src)
            pbe_pkg::SRC_A_HDR: w_byte = r_a_hdr;
            pbe_pkg::SRC_MEM:   w_byte = r_rd_data;
            pbe_pkg::SRC_TAIL0: w_byte = r_a_t0;
            pbe_pkg::SRC_TAIL1: w_byte = r_a_t1;
            pbe_pkg::SRC_B_HDR: w_byte = r_b_hdr;
            pbe_pkg::SRC_B_VAL: w_byte = r_b_val;
            default:            w_byte = '0;
        endcase
    end

    assign w_word = r_acc | (pbe_pkg::WORD_W'(w_byte) << {r_acc_cnt, 3'b000});
    assign w_push = i_cmd.emit && (r_acc_cnt == 2'd3 || i_cmd.fin);
    assign w_adv  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_acc_cnt   <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_acc     <= w_push ? '0 : w_word;
                r_acc_cnt <= w_push ? 2'd0 : r_acc_cnt + 2'd1;
            end
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out_data      <= w_word;
            r_out_cnt       <= pbe_pkg::CNT_W'(r_acc_cnt) + pbe_pkg::CNT_W'(1);
            r_out_last      <= i_cmd.fin;
            r_out_plane_end <= i_cmd.fin && r_job_last;
        end
    end

    assign o_status.adv        = w_adv;
    assign o_status.new_a      = n_a_valid;
    assign o_status.new_b      = n_b_valid;
    assign o_status.a_mem_nz   = (r_a_mcnt != '0);
    assign o_status.a_tail_nz  = (r_a_tcnt != 2'd0);
    assign o_status.a_tail_two = (r_a_tcnt == 2'd2);
    assign o_status.mem_last   = (r_idx == r_a_mcnt);
    assign o_status.b_valid    = r_b_valid;

    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out_data;
    assign o_out_count     = r_out_cnt;
    assign o_out_last      = r_out_last;
    assign o_out_plane_end = r_out_plane_end;

    `PBE_ASSERT_IMP(a_mode_excl, i_clk, i_rst_n, 1'b1, !(r_run_mode && r_have_prev), "open run and held byte at once")
    `PBE_ASSERT_IMP(a_end_is_last, i_clk, i_rst_n, r_out_valid && r_out_plane_end, r_out_last, "plane end on a word that does not close its step")
    `PBE_ASSERT_IMP(a_count_range, i_clk, i_rst_n, r_out_valid, r_out_cnt != '0 && r_out_cnt <= pbe_pkg::CNT_W'(4), "word byte count out of range")

endmodule

[rtl/core/packbits_rle_encoder.sv]
// packbits encoder: a byte that codes nothing is taken and input stays ready; a
// byte that closes packets holds input off while its coded bytes (header, value,
// or one literal store read each) are emitted in turn, each one waiting while
// the output word is not taken; a word is valid in the cycle after its fourth
// or last byte. synchronous active-low reset clears control and encoder state;
// literal store contents are not cleared. depends on pbe_pkg, pbe_ctrl, pbe_dp
module packbits_rle_encoder #(
    parameter int MAX_PACKET = 128
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [7:0]                  i_in_byte,
    input  logic                        i_in_last,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [pbe_pkg::WORD_W-1:0]  o_out_data,
    output logic [pbe_pkg::CNT_W-1:0]   o_out_count,
    output logic                        o_out_last,
    output logic                        o_out_plane_end
);

    pbe_pkg::t_cmd    w_cmd;
    pbe_pkg::t_status w_status;

    pbe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    pbe_dp #(
        .MAX_PACKET (MAX_PACKET)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_in_byte       (i_in_byte),
        .i_in_last       (i_in_last),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_out_data      (o_out_data),
        .o_out_count     (o_out_count),
        .o_out_last      (o_out_last),
        .o_out_plane_end (o_out_plane_end)
    );

endmodule

[tb/testbench.sv]
// self-checking testbench for packbits_rle_encoder: byte planes in, packed coded words out
// depends on pbe_pkg and the encoder rtl; a scoreboard class predicts the coded stream
// and checks every word transfer in order
typedef struct packed {
    logic [pbe_pkg::WORD_W-1:0] data;
    logic [pbe_pkg::CNT_W-1:0]  count;
    logic                       last;
    logic                       plane_end;
} coded_word_t;

class packbits_scoreboard;
    localparam int unsigned WINDOW = 128;

    pbe_pkg::t_byte lit_buf [WINDOW];
    int unsigned    lit_len;
    pbe_pkg::t_byte rep_val;
    int unsigned    rep_len;
    bit             rep_open;
    pbe_pkg::t_byte pend_byte;
    bit             pend_ok;
    pbe_pkg::t_byte step_bytes [$];
    coded_word_t    expected_words [$];
    int unsigned    mismatches;

    function new();
        lit_len   = 0;
        rep_val   = '0;
        rep_len   = 0;
        rep_open  = 0;
        pend_byte = '0;
        pend_ok   = 0;
        mismatches = 0;
    endfunction

    function int unsigned pending();
        return expected_words.size();
    endfunction

    function void close_run();
        step_bytes.push_back(pbe_pkg::t_byte'(257 - rep_len));
        step_bytes.push_back(rep_val);
        rep_open = 0;
        rep_len  = 0;
    endfunction

    function void close_literal();
        if (lit_len == 0) return;
        step_bytes.push_back(pbe_pkg::t_byte'(lit_len - 1));
        for (int k = 0; k < lit_len; k++) step_bytes.push_back(lit_buf[k]);
        lit_len = 0;
    endfunction

    function void take_pending();
        lit_buf[lit_len % WINDOW] = pend_byte;
        lit_len++;
    endfunction

    function void open_run(pbe_pkg::t_byte v);
        pend_ok  = 0;
        rep_open = 1;
        rep_val  = v;
        rep_len  = 2;
        if (rep_len >= WINDOW) close_run();
    endfunction

    // one accepted byte: advance the encoder state and queue the words it produces
    function void note_byte(pbe_pkg::t_byte b, bit last_in);
        coded_word_t w;
        int unsigned n;
        step_bytes.delete();
        if (rep_open) begin
            if (b == rep_val && rep_len < WINDOW) begin
                rep_len++;
                if (rep_len >= WINDOW) close_run();
            end else begin
                close_run();
                pend_byte = b;
                pend_ok   = 1;
            end
        end else if (!pend_ok) begin
            pend_byte = b;
            pend_ok   = 1;
        end else if (b == pend_byte) begin
            if (lit_len == 0) begin
                open_run(b);
            end else if (lit_len + 1 < WINDOW) begin
                close_literal();
                open_run(b);
            end else begin
                // pair straddles the window edge: first byte closes the literal
                take_pending();
                close_literal();
                pend_byte = b;
            end
        end else begin
            take_pending();
            if (lit_len >= WINDOW) close_literal();
            pend_byte = b;
        end
        if (last_in) begin
            if (rep_open) begin
                close_run();
            end else if (pend_ok) begin
                take_pending();
                close_literal();
            end
            pend_ok   = 0;
            pend_byte = '0;
            lit_len   = 0;
        end
        n = step_bytes.size();
        for (int i = 0; i < n; i += 4) begin
            w = '0;
            for (int k = 0; k < 4; k++) begin
                if (i + k < n) begin
                    w.data[8*k +: 8] = step_bytes[i + k];
                    w.count++;
                end
            end
            w.last      = (i + 4 >= n);
            w.plane_end = w.last && last_in;
            expected_words.push_back(w);
        end
    endfunction

    function void check_word(coded_word_t got);
        coded_word_t exp_w;
        if (expected_words.size() == 0) begin
            $display("%0t: unexpected word data=%h count=%0d last=%0b plane_end=%0b",
                     $time, got.data, got.count, got.last, got.plane_end);
            mismatches++;
            return;
        end
        exp_w = expected_words.pop_front();
        if (got.data !== exp_w.data) begin
            $display("%0t: data mismatch, expected %h actual %h", $time, exp_w.data, got.data);
            mismatches++;
        end
        if (got.count !== exp_w.count) begin
            $display("%0t: count mismatch, expected %0d actual %0d",
                     $time, exp_w.count, got.count);
            mismatches++;
        end
        if (got.last !== exp_w.last) begin
            $display("%0t: last mismatch, expected %0b actual %0b", $time, exp_w.last, got.last);
            mismatches++;
        end
        if (got.plane_end !== exp_w.plane_end) begin
            $display("%0t: plane_end mismatch, expected %0b actual %0b",
                     $time, exp_w.plane_end, got.plane_end);
            mismatches++;
        end
    endfunction
endclass

module testbench;
    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic [7:0]                 i_in_byte;
    logic                       i_in_last;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic [pbe_pkg::WORD_W-1:0] o_out_data;
    logic [pbe_pkg::CNT_W-1:0]  o_out_count;
    logic                       o_out_last;
    logic                       o_out_plane_end;

    packbits_scoreboard sb;
    pbe_pkg::t_byte     plane_bytes [$];
    bit                 src_idle;
    bit                 sink_idle;
    int unsigned        random_sent;

    packbits_rle_encoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_byte       (i_in_byte),
        .i_in_last       (i_in_last),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_data      (o_out_data),
        .o_out_count     (o_out_count),
        .o_out_last      (o_out_last),
        .o_out_plane_end (o_out_plane_end)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic send_byte(pbe_pkg::t_byte b, bit last_in);
        if (src_idle && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        i_in_last  <= last_in;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_byte(b, last_in);
    endtask

    task automatic send_plane();
        for (int i = 0; i < plane_bytes.size(); i++)
            send_byte(plane_bytes[i], i == plane_bytes.size() - 1);
    endtask

    task automatic add_run(pbe_pkg::t_byte v, int unsigned n);
        repeat (n) plane_bytes.push_back(v);
    endtask

    // each byte differs from its neighbour so nothing pairs up
    task automatic add_literal(int unsigned n);
        pbe_pkg::t_byte b;
        repeat (n) begin
            do b = pbe_pkg::t_byte'($urandom_range(0, 255));
            while (plane_bytes.size() > 0 && b == plane_bytes[$]);
            plane_bytes.push_back(b);
        end
    endtask

    task automatic build_random_plane();
        int unsigned segs;
        int unsigned len;
        plane_bytes.delete();
        if ($urandom_range(0, 3) == 0) begin
            // noise, often from a tiny alphabet so pairs land anywhere
            len = $urandom_range(1, 24);
            if ($urandom_range(0, 1) == 0)
                repeat (len) plane_bytes.push_back(pbe_pkg::t_byte'($urandom_range(0, 3)));
            else
                repeat (len) plane_bytes.push_back(pbe_pkg::t_byte'($urandom_range(0, 255)));
        end else begin
            segs = $urandom_range(1, 6);
            repeat (segs) begin
                len = ($urandom_range(0, 11) == 0) ? $urandom_range(120, 135)
                                                   : $urandom_range(1, 8);
                if ($urandom_range(0, 1) == 0)
                    add_run(pbe_pkg::t_byte'($urandom_range(0, 255)), len);
                else
                    add_literal(len);
            end
        end
    endtask

    // receiver: check every word transfer, stall in random bursts
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                sb.check_word({o_out_data, o_out_count, o_out_last, o_out_plane_end});
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (sink_idle && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 12);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        #4000000;
        $display("** packbits_rle_encoder: FAILED **");
        $finish;
    end

    initial begin
        sb          = new();
        src_idle    = 0;
        sink_idle   = 0;
        random_sent = 0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_byte  <= '0;
        i_in_last  <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // short planes: extreme values, lone bytes, pairs, short runs and literals
        plane_bytes = '{8'h00};                       send_plane();
        plane_bytes = '{8'hFF};                       send_plane();
        plane_bytes = '{8'h00, 8'h00};                send_plane();
        plane_bytes = '{8'hFF, 8'hFF, 8'hFF};         send_plane();
        plane_bytes = '{8'h01, 8'h02};                send_plane();
        plane_bytes = '{8'hA5, 8'h5A, 8'hA5, 8'hA5, 8'hA5, 8'h3C};
        send_plane();
        src_idle  = 1;
        sink_idle = 1;
        plane_bytes = '{8'h07, 8'h07, 8'h08, 8'h55, 8'hAA, 8'hAA};
        send_plane();

        // window limit: a full run, then a lone byte that starts a new packet
        plane_bytes.delete();
        add_run(pbe_pkg::t_byte'($urandom_range(0, 255)), 128);
        add_literal(1);
        send_plane();

        // sender holds off until the coded stream has fully drained
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);

        while (random_sent < 24) begin
            build_random_plane();
            src_idle  = ($urandom_range(0, 2) != 0);
            sink_idle = ($urandom_range(0, 2) != 0);
            send_plane();
            random_sent += plane_bytes.size();
        end

        // closing plane at full rate: a full literal closed by a pair at its edge,
        // the second byte of the pair then opening a new literal
        src_idle  = 0;
        sink_idle = 0;
        plane_bytes.delete();
        add_literal(128);
        plane_bytes.push_back(plane_bytes[$]);
        add_literal(1);
        send_plane();
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("** packbits_rle_encoder: PASSED **");
        else
            $display("** packbits_rle_encoder: FAILED **");
        $finish;
    end
endmodule

[files.f]
+incdir+rtl/core
rtl/core/pbe_pkg.sv
rtl/core/pbe_ctrl.sv
rtl/core/pbe_dp.sv
rtl/core/packbits_rle_encoder.sv
tb/testbench.sv
